FILE: rtl/core/vrt_pkg.sv
// Shared types and constants for the velocity ramp tracker.
// Used by vrt_const_div, velocity_ramp_tracker, vrt_checker and tb_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package vrt_pkg;

    // field widths
    localparam int SPEED_W   = 32;
    localparam int ACCEL_W   = 24;
    localparam int CFG_IDX_W = 2;

    // acceleration registers come out of reset at this magnitude
    localparam int ACCEL_RESET = 1000000;

    // item kinds carried on s_tuser
    localparam logic MODE_TRACK = 1'b0;
    localparam logic MODE_LOAD  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UP_ACCEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_ACCEL = 2'd1;

    // divider status seen by the top level
    typedef struct packed {
        logic busy;
        logic done;
    } vrt_div_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/vrt_const_div.sv
// Division of an unsigned value by a fixed divisor through reciprocal multiplication.
// Depends on vrt_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module vrt_const_div #(
    parameter int DIVISOR    = 20000,
    parameter int DIVIDEND_W = 24,
    parameter int RMD_W      = 15
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [DIVIDEND_W-1:0]  dividend,
    output vrt_pkg::vrt_div_status_t    status,
    output logic      [DIVIDEND_W-1:0]  quot,
    output logic      [RMD_W-1:0]       rmd
);

    localparam int SHIFT = DIVIDEND_W + $clog2(DIVISOR);
    localparam int M_W   = DIVIDEND_W + 2;
    localparam int P_W   = DIVIDEND_W + M_W;
    // reciprocal rounded up far enough to give the exact quotient for every dividend
    localparam logic [63:0]           RECIP_FULL = ((64'd1 << SHIFT) / 64'(DIVISOR)) + 64'd1;
    localparam logic [M_W-1:0]        RECIP      = M_W'(RECIP_FULL);
    localparam logic [DIVIDEND_W-1:0] DIV_C      = DIVIDEND_W'(DIVISOR);

    logic [DIVIDEND_W-1:0] x_reg;
    logic [DIVIDEND_W-1:0] q_reg, q_next;
    logic [RMD_W-1:0]      r_reg, r_next;
    logic                  s1_reg;
    logic                  s2_reg;
    logic                  done_reg;

    logic [P_W-1:0]        prod;
    logic [DIVIDEND_W-1:0] qd;
    logic [DIVIDEND_W-1:0] diff;

    // quotient from the reciprocal product, remainder from the quotient
    always_comb begin
        prod   = P_W'(x_reg) * P_W'(RECIP);
        q_next = DIVIDEND_W'(prod >> SHIFT);
        qd     = q_reg * DIV_C;
        diff   = x_reg - qd;
        r_next = RMD_W'(diff);
    end

    // control state: one stage per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg   <= 1'b0;
            s2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            s1_reg   <= start;
            s2_reg   <= s1_reg;
            done_reg <= s2_reg;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= dividend;
        end
        if (s1_reg) begin
            q_reg <= q_next;
        end
        if (s2_reg) begin
            r_reg <= r_next;
        end
    end

    assign status.busy = s1_reg | s2_reg | done_reg;
    assign status.done = done_reg;
    assign quot        = q_reg;
    assign rmd         = r_reg;

endmodule

`default_nettype wire

FILE: rtl/core/velocity_ramp_tracker.sv
// Top level of the velocity ramp tracker: stream channels, config port, ramp datapath.
// Depends on vrt_pkg and vrt_const_div.
//
// Usage:
//   s_ channel: one item per control tick. s_tuser is the mode (track goal or
//   load measured speed), s_tdata the signed 32 bit speed value.
//   m_ channel: one result per item, the tracked speed after a track tick or
//   the held output after a load.
//   cfg_ channel: writes up or down acceleration (index 0 or 1). Values of 0
//   or above MAX_ACCEL are dropped. An accepted value is split into whole
//   speed steps and a remainder per tick by a reciprocal multiply, during
//   which cfg_ready and s_tready stay low.
// Pipeline: an item is captured in the input register, and its result is computed
//   from there and registered in the output register. One item per cycle is
//   accepted while m_tready stays high and the divider is not busy; the ramp
//   step is a short add and clamp on precomputed quotient and remainder.
// Reset: tracked speed, remainder and held output clear to zero, both
//   accelerations return to 1000000. No items are lost on a stall: with
//   m_tready low the output register holds its item, the input register
//   takes one more, and then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module velocity_ramp_tracker #(
    parameter int TICK_RATE_HZ = 20000,
    parameter int MAX_ACCEL    = 16777215
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input item channel
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [vrt_pkg::SPEED_W-1:0]   s_tdata,   // [31:0] speed_value
    input  wire logic                          s_tuser,   // [0] mode
    // result channel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [vrt_pkg::SPEED_W-1:0]   m_tdata,   // [31:0] output_speed
    // configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [vrt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [vrt_pkg::ACCEL_W-1:0]   cfg_data
);

    localparam int SW    = vrt_pkg::SPEED_W;
    localparam int AW    = vrt_pkg::ACCEL_W;
    localparam int TW    = $clog2(TICK_RATE_HZ + 1);
    localparam int REM_W = TW + 1;
    localparam int SUM_W = TW + 2;
    localparam int WIDE_W = SW + 2;
    localparam int RESET_Q = vrt_pkg::ACCEL_RESET / TICK_RATE_HZ;
    localparam int RESET_R = vrt_pkg::ACCEL_RESET % TICK_RATE_HZ;
    localparam logic signed [SUM_W-1:0] TICK_S = SUM_W'(TICK_RATE_HZ);
    localparam logic [SW-1:0] MAX_ACCEL_C = SW'(MAX_ACCEL);

    // per-tick steps of each acceleration: whole steps and remainder
    logic [AW-1:0]             up_q_reg, dn_q_reg;
    logic [TW-1:0]             up_r_reg, dn_r_reg;
    logic                      sel_down_reg;

    // ramp state
    logic signed [SW-1:0]      speed_reg, speed_next;
    logic signed [REM_W-1:0]   rem_reg, rem_next;
    logic signed [SW-1:0]      held_reg;

    // input and output registers
    logic                      in_valid_reg;
    logic                      in_mode_reg;
    logic signed [SW-1:0]      in_speed_reg;
    logic                      out_valid_reg;
    logic [SW-1:0]             out_speed_reg, out_speed_next;

    logic                      out_free;
    logic                      advance;
    logic                      cfg_fire;
    logic                      cfg_ok;
    logic                      div_start;
    vrt_pkg::vrt_div_status_t  div_status;
    logic [AW-1:0]             div_quot;
    logic [TW-1:0]             div_rmd;

    // handshake
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !div_status.busy && (!in_valid_reg || out_free);
    assign cfg_ready = !div_status.busy;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_speed_reg;

    // config write: range and index check, then split by the tick rate
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_ok    = (cfg_data != '0) && ({{(SW-AW){1'b0}}, cfg_data} <= MAX_ACCEL_C)
                       && ((cfg_index == vrt_pkg::REG_UP_ACCEL)
                           || (cfg_index == vrt_pkg::REG_DOWN_ACCEL));
    assign div_start = cfg_fire && cfg_ok;

    vrt_const_div #(
        .DIVISOR    (TICK_RATE_HZ),
        .DIVIDEND_W (AW),
        .RMD_W      (TW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (cfg_data),
        .status   (div_status),
        .quot     (div_quot),
        .rmd      (div_rmd)
    );

    // acceleration step registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_q_reg     <= AW'(RESET_Q);
            up_r_reg     <= TW'(RESET_R);
            dn_q_reg     <= AW'(RESET_Q);
            dn_r_reg     <= TW'(RESET_R);
            sel_down_reg <= 1'b0;
        end else begin
            if (div_start) begin
                sel_down_reg <= (cfg_index == vrt_pkg::REG_DOWN_ACCEL);
            end
            if (div_status.done) begin
                if (sel_down_reg) begin
                    dn_q_reg <= div_quot;
                    dn_r_reg <= div_rmd;
                end else begin
                    up_q_reg <= div_quot;
                    up_r_reg <= div_rmd;
                end
            end
        end
    end

    // ramp step for the item in the input register
    always_comb begin
        logic                     go_up;
        logic                     go_dn;
        logic                     use_up;
        logic [AW-1:0]            qa;
        logic [TW-1:0]            ra;
        logic signed [SUM_W-1:0]  ra_ext;
        logic signed [SUM_W-1:0]  rem_ext;
        logic signed [SUM_W-1:0]  sum;
        logic signed [SUM_W-1:0]  rm;
        logic [AW:0]              qm;
        logic signed [WIDE_W-1:0] cur_w;
        logic signed [WIDE_W-1:0] spd_w;
        logic signed [WIDE_W-1:0] limit_w;
        logic                     hit;

        go_up   = in_speed_reg > speed_reg;
        go_dn   = in_speed_reg < speed_reg;
        use_up  = go_up ? (speed_reg >= 0) : (speed_reg <= 0);
        qa      = use_up ? up_q_reg : dn_q_reg;
        ra      = use_up ? up_r_reg : dn_r_reg;
        ra_ext  = signed'({2'b00, ra});
        rem_ext = signed'({rem_reg[REM_W-1], rem_reg});
        // remainder plus this tick's fraction, magnitude in the direction of travel
        sum     = go_up ? (ra_ext + rem_ext) : (ra_ext - rem_ext);

        if (sum >= TICK_S) begin
            qm = {1'b0, qa} + (AW + 1)'(1);
            rm = sum - TICK_S;
        end else if (sum >= 0) begin
            qm = {1'b0, qa};
            rm = sum;
        end else if (qa != '0) begin
            qm = {1'b0, qa} - (AW + 1)'(1);
            rm = sum + TICK_S;
        end else begin
            qm = '0;
            rm = sum;
        end

        cur_w   = WIDE_W'(speed_reg);
        spd_w   = go_up ? (cur_w + signed'({{(WIDE_W-AW-1){1'b0}}, qm}))
                        : (cur_w - signed'({{(WIDE_W-AW-1){1'b0}}, qm}));
        limit_w = use_up ? WIDE_W'(in_speed_reg) : '0;
        hit     = go_up ? (spd_w >= limit_w) : (spd_w <= limit_w);

        speed_next = speed_reg;
        rem_next   = rem_reg;
        if (in_mode_reg == vrt_pkg::MODE_LOAD) begin
            speed_next = in_speed_reg;
            rem_next   = '0;
        end else if (go_up || go_dn) begin
            // clamp at the goal or at zero, dropping the remainder
            if (hit) begin
                speed_next = limit_w[SW-1:0];
                rem_next   = '0;
            end else begin
                speed_next = spd_w[SW-1:0];
                rem_next   = go_up ? rm[REM_W-1:0] : -rm[REM_W-1:0];
            end
        end

        out_speed_next = (in_mode_reg == vrt_pkg::MODE_LOAD) ? held_reg : speed_next;
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg  <= s_tuser;
            in_speed_reg <= s_tdata;
        end
    end

    // ramp state, updated as an item moves into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= '0;
            rem_reg   <= '0;
            held_reg  <= '0;
        end else if (advance) begin
            speed_reg <= speed_next;
            rem_reg   <= rem_next;
            if (in_mode_reg == vrt_pkg::MODE_TRACK) begin
                held_reg <= speed_next;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_speed_reg <= out_speed_next;
        end
    end

endmodule

`default_nettype wire

FILE: test/vrt_checker.sv
// Scoreboard for the velocity ramp tracker: watches the item, result and config channels.
// Keeps its own ramp state, predicts each output speed and compares in order.
// Depends on vrt_pkg only.
`timescale 1ns / 1ps

module vrt_checker #(
    parameter int TICK_RATE_HZ = 20000,
    parameter int MAX_ACCEL    = 16777215
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [vrt_pkg::SPEED_W-1:0]   s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [vrt_pkg::SPEED_W-1:0]   m_tdata,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [vrt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vrt_pkg::ACCEL_W-1:0]   cfg_data,
    output int                            speed_errors,
    output int                            speeds_pending
);

    import vrt_pkg::*;

    // shadow of the acceleration registers and the ramp state
    logic        [ACCEL_W-1:0] up_accel;
    logic        [ACCEL_W-1:0] down_accel;
    logic signed [SPEED_W-1:0] cur_speed;
    logic signed [SPEED_W-1:0] step_remainder;
    logic signed [SPEED_W-1:0] held_speed;

    // output speeds still owed by the block, oldest first
    logic [SPEED_W-1:0] owed_speed_q[$];

    // one tick of integration: returns the unclamped speed, hands back the new remainder
    function automatic longint ramp_advance(input longint cur, input longint rem_in,
                                            input longint accel, output longint rem_out);
        longint sum;
        sum     = rem_in + accel;
        rem_out = sum % TICK_RATE_HZ;
        return cur + sum / TICK_RATE_HZ;
    endfunction

    // update the ramp state for one accepted item and queue the speed it returns
    task automatic predict_speed(input logic mode, input logic [SPEED_W-1:0] value);
        longint goal;
        longint cur;
        longint rem;
        longint spd;
        longint up;
        longint dn;
        goal = longint'($signed(value));
        cur  = longint'(cur_speed);
        rem  = longint'(step_remainder);
        up   = longint'(up_accel);
        dn   = longint'(down_accel);

        // load: new start speed, result is the last tracked output
        if (mode == MODE_LOAD) begin
            cur_speed      = value;
            step_remainder = '0;
            owed_speed_q.push_back(held_speed);
            return;
        end

        if (goal > cur) begin
            if (cur >= 0) begin
                // speeding up away from zero, stop at the goal
                spd = ramp_advance(cur, rem, up, rem);
                if (spd >= goal) begin
                    rem = 0;
                    spd = goal;
                end
            end else begin
                // slowing down toward zero from below
                spd = ramp_advance(cur, rem, dn, rem);
                if (spd >= 0) begin
                    rem = 0;
                    spd = 0;
                end
            end
        end else if (goal < cur) begin
            if (cur <= 0) begin
                spd = ramp_advance(cur, rem, -up, rem);
                if (spd <= goal) begin
                    rem = 0;
                    spd = goal;
                end
            end else begin
                spd = ramp_advance(cur, rem, -dn, rem);
                if (spd <= 0) begin
                    rem = 0;
                    spd = 0;
                end
            end
        end else begin
            // goal reached: speed stays, remainder kept
            spd = goal;
        end

        cur_speed      = SPEED_W'(spd);
        step_remainder = SPEED_W'(rem);
        held_speed     = cur_speed;
        owed_speed_q.push_back(held_speed);
    endtask

    // sample all channels at the rising edge
    always @(posedge aclk) begin
        logic [SPEED_W-1:0] want;
        if (!aresetn) begin
            up_accel       = ACCEL_W'(ACCEL_RESET);
            down_accel     = ACCEL_W'(ACCEL_RESET);
            cur_speed      = '0;
            step_remainder = '0;
            held_speed     = '0;
            owed_speed_q.delete();
            speed_errors   = 0;
        end else begin
            // results first: a result never belongs to an item accepted on the same edge
            if (m_tvalid && m_tready) begin
                if (owed_speed_q.size() == 0) begin
                    $display("%0t: output_speed expected none got %0d", $time,
                             $signed(m_tdata));
                    speed_errors++;
                end else begin
                    want = owed_speed_q.pop_front();
                    if (m_tdata !== want) begin
                        $display("%0t: output_speed expected %0d got %0d", $time,
                                 $signed(want), $signed(m_tdata));
                        speed_errors++;
                    end
                end
            end

            // register writes: zero or oversized values and spare indexes do nothing
            if (cfg_valid && cfg_ready) begin
                if (cfg_data != '0 && int'(cfg_data) <= MAX_ACCEL) begin
                    case (cfg_index)
                        REG_UP_ACCEL: begin
                            up_accel = cfg_data;
                        end
                        REG_DOWN_ACCEL: begin
                            down_accel = cfg_data;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            if (s_tvalid && s_tready)
                predict_speed(s_tuser, s_tdata);
        end
        speeds_pending = owed_speed_q.size();
    end

endmodule

FILE: test/tb_top.sv
// Testbench top for the velocity ramp tracker: clock, reset, item and config stimulus.
// Instantiates velocity_ramp_tracker and vrt_checker; depends on vrt_pkg.
`timescale 1ns / 1ps

module tb_top;

    import vrt_pkg::*;

    localparam int TICK_RATE = 20000;
    localparam int ACCEL_MAX = 16777215;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 180;
    localparam int HOLD_CYCLES = 300;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [SPEED_W-1:0]   s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [SPEED_W-1:0]   m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ACCEL_W-1:0]   cfg_data;

    int speed_errors;
    int speeds_pending;

    // idling controls for the sender and the receiver
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_off_req;

    velocity_ramp_tracker #(
        .TICK_RATE_HZ(TICK_RATE),
        .MAX_ACCEL   (ACCEL_MAX)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    vrt_checker #(
        .TICK_RATE_HZ(TICK_RATE),
        .MAX_ACCEL   (ACCEL_MAX)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .speed_errors  (speed_errors),
        .speeds_pending(speeds_pending)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // result receiver: random stalls, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    // offer one item from a falling edge, return at the falling edge after acceptance
    task automatic send_item(input logic mode, input logic [SPEED_W-1:0] value);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = value;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // stop offering until every owed speed is back, then let the pipe settle
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (speeds_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ACCEL_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // speed value: mostly near zero so goals get reached and the sign flips
    function automatic logic [SPEED_W-1:0] pick_speed();
        int span;
        case ($urandom_range(0, 9))
            0: begin
                return $urandom;
            end
            1: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h7fff_ffff;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'hffff_ffff;
                    default: return 32'h0000_0001;
                endcase
            end
            default: begin
                span = $urandom_range(0, 1) ? 2000 : 100;
                return SPEED_W'(int'($urandom_range(0, 2 * span)) - span);
            end
        endcase
    endfunction

    // stimulus
    initial begin
        logic mode;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = MODE_TRACK;
        cfg_valid    = 1'b0;
        cfg_index    = REG_UP_ACCEL;
        cfg_data     = '0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        hold_off_req = 1'b0;
        aresetn      = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset accelerations: goal reached at zero, ramp up and clamp at the goal
        send_item(MODE_TRACK, 32'd0);
        repeat (4) send_item(MODE_TRACK, 32'd120);
        // down through zero with the clamp there, then out the other side
        repeat (4) send_item(MODE_TRACK, -32'sd30);
        // loads return the held output; full-scale differences both ways
        send_item(MODE_LOAD, 32'h7fff_ffff);
        repeat (2) send_item(MODE_TRACK, 32'h8000_0000);
        send_item(MODE_LOAD, 32'h8000_0000);
        repeat (2) send_item(MODE_TRACK, 32'h7fff_ffff);
        send_item(MODE_LOAD, 32'd5);
        send_item(MODE_TRACK, 32'd5);
        send_item(MODE_LOAD, 32'd0);
        send_item(MODE_TRACK, 32'hffff_ffff);
        wait_idle();

        // dropped writes, then the extreme settings
        write_reg(REG_UP_ACCEL, '0);
        write_reg(REG_DOWN_ACCEL, '0);
        write_reg(REG_SPARE_LO, ACCEL_W'($urandom));
        write_reg(REG_SPARE_HI, ACCEL_W'($urandom));
        write_reg(REG_UP_ACCEL, ACCEL_W'(ACCEL_MAX));
        write_reg(REG_DOWN_ACCEL, ACCEL_W'(1));
        send_item(MODE_LOAD, 32'd0);
        repeat (3) send_item(MODE_TRACK, 32'h7fff_ffff);
        repeat (2) send_item(MODE_TRACK, 32'h8000_0000);
        wait_idle();

        // random phases, each under its own acceleration setting
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          ACCEL_W'($urandom));
                write_reg($urandom_range(0, 1) ? REG_UP_ACCEL : REG_DOWN_ACCEL, '0);
                case (p)
                    1: begin
                        write_reg(REG_UP_ACCEL, ACCEL_W'(1));
                        write_reg(REG_DOWN_ACCEL, ACCEL_W'(ACCEL_MAX));
                    end
                    2: begin
                        write_reg(REG_UP_ACCEL, ACCEL_W'($urandom));
                        write_reg(REG_DOWN_ACCEL, ACCEL_W'($urandom));
                    end
                    3: begin
                        write_reg(REG_UP_ACCEL, ACCEL_W'(TICK_RATE));
                        write_reg(REG_DOWN_ACCEL, ACCEL_W'(2 * TICK_RATE + 1));
                    end
                    4: begin
                        write_reg(REG_UP_ACCEL, ACCEL_W'($urandom_range(1, 40000)));
                        write_reg(REG_DOWN_ACCEL, ACCEL_W'($urandom_range(1, 40000)));
                    end
                    default: begin
                        write_reg(REG_UP_ACCEL, ACCEL_W'(ACCEL_MAX));
                        write_reg(REG_DOWN_ACCEL, ACCEL_W'(ACCEL_MAX));
                    end
                endcase
            end
            // last phase runs back to back
            tx_idle_on = (p != PHASES - 1);
            rx_idle_on = (p != PHASES - 1);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 2 && i == 60)
                    hold_off_req = 1'b1;
                if (p == 1 && i == 90)
                    wait_idle();
                mode = ($urandom_range(0, 99) < 8) ? MODE_LOAD : MODE_TRACK;
                send_item(mode, pick_speed());
            end
            wait_idle();
        end

        repeat (10) @(negedge aclk);
        if (speed_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: velocity_ramp_tracker.f
rtl/core/vrt_pkg.sv
rtl/core/vrt_const_div.sv
rtl/core/velocity_ramp_tracker.sv
test/vrt_checker.sv
test/tb_top.sv
